[design/yee_field_stencil_update_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Yee field stencil update block
// Each macro expands to a concurrent assertion in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef YEE_FIELD_STENCIL_UPDATE_ASSERT_SVH
`define YEE_FIELD_STENCIL_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define YFS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yfs assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define YFS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yfs assertion failed");
`else
`define YFS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define YFS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

[design/yfs_pkg.sv]
// ----------------------------------------------------------------------------
// yfs_pkg
// Shared constants, types and register map of the Yee field stencil update.
// ----------------------------------------------------------------------------
package yfs_pkg;

  localparam int MAX_X  = 64;
  localparam int MAX_Y  = 64;
  localparam int MAX_Z  = 4096;
  localparam int DEPTH  = MAX_X * MAX_Y;
  localparam int AW     = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_X);
  localparam int YW     = $clog2(MAX_Y);
  localparam int ZW     = $clog2(MAX_Z);
  localparam int SXW    = XW + 1;
  localparam int SYW    = YW + 1;
  localparam int SZW    = ZW + 1;
  localparam int PW     = AW + 1;
  localparam int FW     = 32;
  localparam int CW     = FW + 2;
  localparam int PCW    = CW + 17;
  localparam int PJW    = FW + 17;
  localparam int ACW    = FW + 26;
  localparam int RW     = ACW - 15;
  localparam int SW     = RW + 1;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int RCW    = $clog2(AW);

  typedef enum logic [2:0] {
    REG_COURANT   = 3'd0,
    REG_TIME_STEP = 3'd1,
    REG_SIZE_X    = 3'd2,
    REG_SIZE_Y    = 3'd3,
    REG_SIZE_Z    = 3'd4
  } reg_idx_e;

  typedef logic signed [FW-1:0] fld_t;

  typedef struct packed {
    logic [15:0]    courant;
    logic [15:0]    time_step;
    logic [SXW-1:0] sx;
    logic [SYW-1:0] sy;
    logic [SZW-1:0] sz;
    logic [PW-1:0]  plane;
  } cfg_t;

  typedef struct packed {
    logic           op;
    logic           interior;
    logic           last;
    fld_t [2:0]     own;
    fld_t [2:0]     oth;
    fld_t [2:0]     cj;
    fld_t [2:0]     nx;
    fld_t [2:0]     ny;
    fld_t [2:0]     nz;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/yfs_cfg.sv]
// ----------------------------------------------------------------------------
// yfs_cfg
// Register file on the APB-style port; supplies clamped sizes and plane size.
// ----------------------------------------------------------------------------
module yfs_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output yfs_pkg::cfg_t cfg_o
);
  import yfs_pkg::*;

  logic [15:0]    courant_q, time_step_q;
  logic [6:0]     size_x_q, size_y_q;
  logic [12:0]    size_z_q;
  logic           wr_en;
  reg_idx_e       idx;
  logic [SXW-1:0] sx;
  logic [SYW-1:0] sy;
  logic [SZW-1:0] sz;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      courant_q   <= 16'd16384;
      time_step_q <= 16'd256;
      size_x_q    <= 7'd64;
      size_y_q    <= 7'd64;
      size_z_q    <= 13'd64;
    end else if (wr_en) begin
      unique case (idx)
        REG_COURANT:   courant_q   <= pwdata[15:0];
        REG_TIME_STEP: time_step_q <= pwdata[15:0];
        REG_SIZE_X:    size_x_q    <= pwdata[6:0];
        REG_SIZE_Y:    size_y_q    <= pwdata[6:0];
        REG_SIZE_Z:    size_z_q    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COURANT:   prdata = {16'd0, courant_q};
      REG_TIME_STEP: prdata = {16'd0, time_step_q};
      REG_SIZE_X:    prdata = {25'd0, size_x_q};
      REG_SIZE_Y:    prdata = {25'd0, size_y_q};
      REG_SIZE_Z:    prdata = {19'd0, size_z_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_comb begin
    sx = (size_x_q < 7'd2) ? SXW'(2) : ((size_x_q > 7'(MAX_X)) ? SXW'(MAX_X) : size_x_q);
    sy = (size_y_q < 7'd2) ? SYW'(2) : ((size_y_q > 7'(MAX_Y)) ? SYW'(MAX_Y) : size_y_q);
    sz = (size_z_q < 13'd2) ? SZW'(2) :
         ((size_z_q > 13'(MAX_Z)) ? SZW'(MAX_Z) : size_z_q);
    cfg_o.courant   = courant_q;
    cfg_o.time_step = time_step_q;
    cfg_o.sx        = sx;
    cfg_o.sy        = sy;
    cfg_o.sz        = sz;
    cfg_o.plane     = PW'(sx) * PW'(sy);
  end

endmodule

[design/yfs_front.sv]
// ----------------------------------------------------------------------------
// yfs_front
// Accepts cells, tracks the grid position, classifies edge cells and reads
// the three stencil neighbors from the plane-long delay line.
// ----------------------------------------------------------------------------
module yfs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  yfs_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          opcode_i,
  input  logic          first_cell_i,
  input  yfs_pkg::fld_t ex_i,
  input  yfs_pkg::fld_t ey_i,
  input  yfs_pkg::fld_t ez_i,
  input  yfs_pkg::fld_t bx_i,
  input  yfs_pkg::fld_t by_i,
  input  yfs_pkg::fld_t bz_i,
  input  yfs_pkg::fld_t jx_i,
  input  yfs_pkg::fld_t jy_i,
  input  yfs_pkg::fld_t jz_i,
  input  logic          q_full_i,
  output logic          push_o,
  output yfs_pkg::item_t item_o
);
  import yfs_pkg::*;

  typedef enum logic {ST_RUN, ST_REDUCE} state_e;

  state_e           state_q;
  logic [RCW-1:0]   red_cnt_q;
  logic [AW-1:0]    ring_q;
  logic [XW-1:0]    pos_x_q;
  logic [YW-1:0]    pos_y_q;
  logic [ZW-1:0]    pos_z_q;
  logic             s2_valid_q;

  logic [3*FW-1:0]  bank_x [DEPTH];
  logic [3*FW-1:0]  bank_y [DEPTH];
  logic [3*FW-1:0]  bank_z [DEPTH];
  logic [3*FW-1:0]  rd_x_q, rd_y_q, rd_z_q;
  item_t            s2_q;

  logic             accept, adv, need_reduce;
  logic [AW-1:0]    az, ax, ay, ring_nxt;
  logic [XW-1:0]    cx, nxt_x;
  logic [YW-1:0]    cy, nxt_y;
  logic [ZW-1:0]    cz, nxt_z;
  logic             carry_x, carry_y, in_grid, interior, last;
  logic [2*AW-1:0]  red_div;
  fld_t [2:0]       own, oth;

  assign adv         = !s2_valid_q || !q_full_i;
  assign need_reduce = !first_cell_i && ({1'b0, ring_q} >= cfg_i.plane);
  assign in_stall_o  = (state_q != ST_RUN) || need_reduce || !adv;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = s2_valid_q && !q_full_i;
  assign red_div     = (2*AW)'(cfg_i.plane) << red_cnt_q;

  always_comb begin
    own = opcode_i ? {bz_i, by_i, bx_i} : {ez_i, ey_i, ex_i};
    oth = opcode_i ? {ez_i, ey_i, ex_i} : {bz_i, by_i, bx_i};

    if (first_cell_i) begin
      az = '0;
      cx = opcode_i ? '0 : XW'(cfg_i.sx - SXW'(1));
      cy = opcode_i ? '0 : YW'(cfg_i.sy - SYW'(1));
      cz = opcode_i ? '0 : ZW'(cfg_i.sz - SZW'(1));
    end else begin
      az = ring_q;
      cx = pos_x_q;
      cy = pos_y_q;
      cz = pos_z_q;
    end

    ax = (az == '0) ? AW'(cfg_i.plane - PW'(1)) : AW'(az - AW'(1));
    ay = ({1'b0, az} >= PW'(cfg_i.sx)) ? AW'({1'b0, az} - PW'(cfg_i.sx))
                                      : AW'({1'b0, az} + cfg_i.plane - PW'(cfg_i.sx));
    ring_nxt = ({1'b0, az} + PW'(1) >= cfg_i.plane) ? '0 : AW'(az + AW'(1));

    in_grid = ({1'b0, cx} < cfg_i.sx) && ({1'b0, cy} < cfg_i.sy) &&
              ({1'b0, cz} < cfg_i.sz);
    if (!opcode_i) begin
      interior = in_grid && ({1'b0, cx} + SXW'(1) < cfg_i.sx) &&
                 ({1'b0, cy} + SYW'(1) < cfg_i.sy) && ({1'b0, cz} + SZW'(1) < cfg_i.sz);
      last     = in_grid && (cx == '0) && (cy == '0) && (cz == '0);
      // Descending order; a counter beyond the grid wraps to its top index.
      carry_x = (cx == '0) || ({1'b0, cx} >= cfg_i.sx);
      nxt_x   = carry_x ? XW'(cfg_i.sx - SXW'(1)) : cx - XW'(1);
      carry_y = (cy == '0) || ({1'b0, cy} >= cfg_i.sy);
      nxt_y   = !carry_x ? cy : (carry_y ? YW'(cfg_i.sy - SYW'(1)) : cy - YW'(1));
      if (carry_x && carry_y) begin
        nxt_z = ((cz == '0) || ({1'b0, cz} >= cfg_i.sz)) ? ZW'(cfg_i.sz - SZW'(1))
                                                       : cz - ZW'(1);
      end else begin
        nxt_z = cz;
      end
    end else begin
      interior = in_grid && (cx != '0) && (cy != '0) && (cz != '0);
      last     = in_grid && ({1'b0, cx} == cfg_i.sx - SXW'(1)) &&
                 ({1'b0, cy} == cfg_i.sy - SYW'(1)) && ({1'b0, cz} == cfg_i.sz - SZW'(1));
      carry_x = ({1'b0, cx} + SXW'(1) >= cfg_i.sx);
      nxt_x   = carry_x ? '0 : cx + XW'(1);
      carry_y = ({1'b0, cy} + SYW'(1) >= cfg_i.sy);
      nxt_y   = !carry_x ? cy : (carry_y ? '0 : cy + YW'(1));
      if (carry_x && carry_y) begin
        nxt_z = ({1'b0, cz} + SZW'(1) >= cfg_i.sz) ? '0 : cz + ZW'(1);
      end else begin
        nxt_z = cz;
      end
    end
  end

  // A ring pointer left beyond a shrunken plane is brought back into range
  // by a shift-and-subtract remainder, one bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      red_cnt_q  <= '0;
      ring_q     <= '0;
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      pos_z_q    <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_RUN: begin
          if (in_valid_i && need_reduce && adv) begin
            state_q   <= ST_REDUCE;
            red_cnt_q <= RCW'(AW - 1);
          end
        end
        ST_REDUCE: begin
          if ((2*AW)'(ring_q) >= red_div) begin
            ring_q <= ring_q - red_div[AW-1:0];
          end
          red_cnt_q <= red_cnt_q - RCW'(1);
          if (red_cnt_q == '0) begin
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
      if (accept) begin
        ring_q  <= ring_nxt;
        pos_x_q <= nxt_x;
        pos_y_q <= nxt_y;
        pos_z_q <= nxt_z;
      end
      if (accept) begin
        s2_valid_q <= 1'b1;
      end else if (push_o) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Read-first delay line: the entry at the current cell is read before the
  // other field of this cell overwrites it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_x_q    <= bank_x[ax];
      rd_y_q    <= bank_y[ay];
      rd_z_q    <= bank_z[az];
      bank_x[az] <= oth;
      bank_y[az] <= oth;
      bank_z[az] <= oth;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_q.op       <= opcode_i;
      s2_q.interior <= interior;
      s2_q.last     <= last;
      s2_q.own      <= own;
      s2_q.oth      <= oth;
      s2_q.cj       <= {jz_i, jy_i, jx_i};
      s2_q.nx       <= '0;
      s2_q.ny       <= '0;
      s2_q.nz       <= '0;
    end
  end

  always_comb begin
    item_o    = s2_q;
    item_o.nx = rd_x_q;
    item_o.ny = rd_y_q;
    item_o.nz = rd_z_q;
  end

endmodule

[design/yfs_queue.sv]
// ----------------------------------------------------------------------------
// yfs_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module yfs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  yfs_pkg::item_t     item_i,
  input  logic               pop_i,
  output yfs_pkg::item_t     item_o,
  output yfs_pkg::q_status_t stat_o
);
  import yfs_pkg::*;

  item_t          slot_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q;

  assign stat_o.full  = (count_q == (QAW+1)'(QDEPTH));
  assign stat_o.empty = (count_q == '0);
  assign item_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[design/yfs_back.sv]
// ----------------------------------------------------------------------------
// yfs_back
// Three-stage arithmetic: curl sums, products, then rounding and saturation
// into the output register.
// ----------------------------------------------------------------------------
module yfs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  yfs_pkg::cfg_t  cfg_i,
  input  yfs_pkg::item_t item_i,
  input  logic           q_empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output yfs_pkg::fld_t  new_x_o,
  output yfs_pkg::fld_t  new_y_o,
  output yfs_pkg::fld_t  new_z_o,
  output logic           was_updated_o,
  output logic           last_cell_o
);
  import yfs_pkg::*;

  logic                  en;
  logic                  v1_q, v2_q, out_valid_q;
  logic signed [CW-1:0]  c_d [3];
  logic signed [CW-1:0]  c1_q [3];
  fld_t [2:0]            own1_q, j1_q, own2_q;
  logic                  op1_q, int1_q, last1_q, int2_q, last2_q;
  logic signed [PCW-1:0] pc_q [3];
  logic signed [PJW-1:0] pj_q [3];
  logic signed [ACW-1:0] acc [3];
  logic signed [SW-1:0]  sum [3];
  fld_t [2:0]            res;
  fld_t [2:0]            out_q;
  logic                  upd_q, last_q;

  function automatic logic signed [CW-1:0] ext(input fld_t v);
    return {{(CW-FW){v[FW-1]}}, v};
  endfunction

  assign en          = !out_valid_q || !out_stall_i;
  assign pop_o       = en && !q_empty_i;
  assign out_valid_o = out_valid_q;

  // Both passes share one curl form once the other field is taken as oth.
  always_comb begin
    c_d[0] = (ext(item_i.ny[2]) - ext(item_i.oth[2])) -
             (ext(item_i.nz[1]) - ext(item_i.oth[1]));
    c_d[1] = (ext(item_i.nz[0]) - ext(item_i.oth[0])) -
             (ext(item_i.nx[2]) - ext(item_i.oth[2]));
    c_d[2] = (ext(item_i.nx[1]) - ext(item_i.oth[1])) -
             (ext(item_i.ny[0]) - ext(item_i.oth[0]));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = ACW'(pc_q[k]) - (ACW'(pj_q[k]) <<< 7);
      acc[k] = acc[k] + ACW'(16384);
      sum[k] = SW'(own2_q[k]) + SW'($signed(acc[k][ACW-1:15]));
      if (!int2_q) begin
        res[k] = own2_q[k];
      end else if (sum[k] > SW'(32'sh7fffffff)) begin
        res[k] = 32'sh7fffffff;
      end else if (sum[k] < -SW'(33'sh080000000)) begin
        res[k] = 32'sh80000000;
      end else begin
        res[k] = sum[k][FW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop_o;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c1_q[k] <= c_d[k];
        pc_q[k] <= c1_q[k] * $signed({1'b0, cfg_i.courant});
        if (op1_q) begin
          pj_q[k] <= '0;
        end else begin
          pj_q[k] <= j1_q[k] * $signed({1'b0, cfg_i.time_step});
        end
      end
      own1_q  <= item_i.own;
      j1_q    <= item_i.cj;
      op1_q   <= item_i.op;
      int1_q  <= item_i.interior;
      last1_q <= item_i.last;
      own2_q  <= own1_q;
      int2_q  <= int1_q;
      last2_q <= last1_q;
      out_q   <= res;
      upd_q   <= int2_q;
      last_q  <= last2_q;
    end
  end

  assign new_x_o       = out_q[0];
  assign new_y_o       = out_q[1];
  assign new_z_o       = out_q[2];
  assign was_updated_o = upd_q;
  assign last_cell_o   = last_q;

endmodule

[design/yee_field_stencil_update.sv]
// ----------------------------------------------------------------------------
// yee_field_stencil_update
// Streams grid cells of one Yee leapfrog half-step and returns updated E or B.
// ----------------------------------------------------------------------------
// Usage: cells enter on the in channel (in_valid_i / in_stall_o), one request
// per cell, E, B and J of the cell plus opcode and first_cell. Opcode 0 runs
// an electric pass in descending raster order, opcode 1 a magnetic pass in
// ascending order; first_cell starts a pass. Each cell yields one result on
// the out channel (out_valid_o / out_stall_i) in input order.
// Throughput is one cell per cycle while no stall holds the flow, set by the
// delay line banks, each read once and written once per cell. An accepted cell
// passes the front register, the queue and the back end. After a size change
// in mid-pass a remainder unit holds input and reduces the ring pointer.
// Reset clears position, ring pointer, queue and pipeline valid flags and
// loads default registers; the delay line is not cleared and must be filled
// by a pass that starts with first_cell. When the receiver stalls, the back
// end holds, the queue fills, and then in_stall_o rises.
// Registers sit on the APB-style port at byte addresses 0 to 16.
// ----------------------------------------------------------------------------
`include "yee_field_stencil_update_assert.svh"

module yee_field_stencil_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic        first_cell_i,
  input  logic signed [31:0] ex_i,
  input  logic signed [31:0] ey_i,
  input  logic signed [31:0] ez_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] bz_i,
  input  logic signed [31:0] jx_i,
  input  logic signed [31:0] jy_i,
  input  logic signed [31:0] jz_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  output logic        was_updated_o,
  output logic        last_cell_o
);
  import yfs_pkg::*;

  cfg_t      cfg;
  item_t     push_item, pop_item;
  logic      q_push, q_pop;
  q_status_t q_stat;

  yfs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  yfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .first_cell_i (first_cell_i),
    .ex_i         (ex_i),
    .ey_i         (ey_i),
    .ez_i         (ez_i),
    .bx_i         (bx_i),
    .by_i         (by_i),
    .bz_i         (bz_i),
    .jx_i         (jx_i),
    .jy_i         (jy_i),
    .jz_i         (jz_i),
    .q_full_i     (q_stat.full),
    .push_o       (q_push),
    .item_o       (push_item)
  );

  yfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  yfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_i        (pop_item),
    .q_empty_i     (q_stat.empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .new_x_o       (new_x_o),
    .new_y_o       (new_y_o),
    .new_z_o       (new_z_o),
    .was_updated_o (was_updated_o),
    .last_cell_o   (last_cell_o)
  );

  `YFS_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, q_push, !q_stat.full)
  `YFS_ASSERT_IMP(a_pop_has_data, clk_i, rst_ni, q_pop, !q_stat.empty)
  `YFS_ASSERT_NXT(a_push_fills, clk_i, rst_ni, q_push && !q_pop, !q_stat.empty)
  `YFS_ASSERT_IMP(a_last_is_updated, clk_i, rst_ni, out_valid_o && last_cell_o, was_updated_o)

endmodule
